>>> rtl/core/bca_pkg.sv
// Package for the contiguous bitmap allocator.
// Holds request mode codes, the controller state type and the run step result.
// No dependencies.
`default_nettype none

package bca_pkg;

    // Request mode codes carried in the mode field.
    localparam logic [2:0] MODE_SCAN      = 3'd0;
    localparam logic [2:0] MODE_TEST      = 3'd1;
    localparam logic [2:0] MODE_SET       = 3'd2;
    localparam logic [2:0] MODE_CLEAR     = 3'd3;
    localparam logic [2:0] MODE_CLEAR_ALL = 3'd4;

    localparam int          UNITS_PER_BYTE = 8;
    localparam logic [6:0]  BYTES_RESET    = 7'd64;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_MOD   = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    // Result of running one map byte through the free run counter.
    typedef struct packed {
        logic       hit;
        logic [2:0] hit_bit;
        logic [9:0] len;
    } t_step;

endpackage

`default_nettype wire

>>> rtl/core/bca_in_if.sv
// Request channel of the contiguous bitmap allocator.
// Carries valid, ready and one request; no dependencies.
`default_nettype none

interface bca_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [8:0] bit_index;
    logic [9:0] run_length;

    modport source (output valid, output mode, output bit_index, output run_length,
                    input ready);
    modport sink   (input valid, input mode, input bit_index, input run_length,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/bca_out_if.sv
// Response channel of the contiguous bitmap allocator.
// Carries valid, ready and one result; no dependencies.
`default_nettype none

interface bca_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [8:0] start_index;
    logic       bit_value;

    modport source (output valid, output found, output start_index, output bit_value,
                    input ready);
    modport sink   (input valid, input found, input start_index, input bit_value,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/bca_run_step.sv
// Free run counter for one map byte, lowest unit first.
// Depends on bca_pkg for the step result struct.
`default_nettype none

module bca_run_step (
    input  wire logic [7:0]   i_byte,
    input  wire logic [9:0]   i_len,
    input  wire logic [9:0]   i_want,
    output bca_pkg::t_step    o_step
);
    import bca_pkg::*;

    // Each free unit extends the run, a taken unit restarts it; the first
    // position where the run reaches the wanted length is kept.
    always_comb begin
        logic [9:0] len;
        logic       hit;
        logic [2:0] hit_bit;
        len     = i_len;
        hit     = 1'b0;
        hit_bit = 3'd0;
        for (int b = 0; b < UNITS_PER_BYTE; b++) begin
            if (i_byte[b]) begin
                len = 10'd0;
            end else begin
                len = len + 10'd1;
            end
            if (!hit && (len == i_want)) begin
                hit     = 1'b1;
                hit_bit = 3'(b);
            end
        end
        o_step.hit     = hit;
        o_step.hit_bit = hit_bit;
        o_step.len     = len;
    end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_contiguous_allocator_top.sv
// Top level of the contiguous first-fit bitmap allocator.
// Depends on bca_pkg, bca_in_if, bca_out_if and bca_run_step.
//
//  Channel   | Direction | Handshake            | Contents
//  i_req     | in        | valid/ready          | mode, bit_index, run_length
//  o_rsp     | out       | valid/ready          | found, start_index, bit_value
//  i_cfg_*   | in        | write enable, no wait | bytes_in_use
//
// Scan reads at most min(bytes_in_use, MAP_BYTES) bytes: the map memory
// is read one byte per cycle and each byte runs through the run counter.
// Test, set and clear go through read, modify and result. Clear all and the
// pass after reset clear all MAP_BYTES map bytes, one map byte
// written per cycle; no request is taken during the pass. A stalled response
// holds in the output register while the next request is already taken and
// worked on.
`default_nettype none

module bitmap_contiguous_allocator_top #(
    parameter int MAP_BYTES = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bca_in_if.sink     i_req,
    bca_out_if.source  o_rsp,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata
);
    import bca_pkg::*;

    localparam int          AW          = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam logic [12:0] MAP_BYTES_W = 13'(MAP_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

    // Map store.
    logic [7:0]    mem [MAP_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;

    t_state        r_state, n_state;
    logic [6:0]    r_bytes_in_use;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_init, n_init;
    logic [2:0]    r_mode, n_mode;
    logic [AW-1:0] r_req_addr, n_req_addr;
    logic [2:0]    r_req_bit, n_req_bit;
    logic [9:0]    r_want, n_want;
    logic [6:0]    r_lim, n_lim;
    logic [6:0]    r_rd_byte, n_rd_byte;
    logic [6:0]    r_pbyte, n_pbyte;
    logic          r_pv, n_pv;
    logic [9:0]    r_len, n_len;
    logic          r_res_found, n_res_found;
    logic [8:0]    r_res_start, n_res_start;
    logic          r_res_bit, n_res_bit;
    logic          r_out_valid, n_out_valid;
    logic          r_out_found, n_out_found;
    logic [8:0]    r_out_start, n_out_start;
    logic          r_out_bit, n_out_bit;

    t_step         step;
    logic          req_xfer;
    logic [6:0]    lim_bytes;
    logic [12:0]   req_byte;
    logic [12:0]   rd_byte_w;
    logic [7:0]    bit_mask;
    logic [10:0]   start_sum;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // Bytes actually scanned: the register bounded by the store size.
    assign lim_bytes = ({6'd0, r_bytes_in_use} > MAP_BYTES_W) ? MAP_BYTES_W[6:0]
                                                              : r_bytes_in_use;
    assign req_byte  = {7'd0, i_req.bit_index[8:3]};
    assign rd_byte_w = {6'd0, r_rd_byte};
    assign bit_mask  = 8'd1 << r_req_bit;
    assign start_sum = 11'({r_pbyte, step.hit_bit}) + 11'd1 - {1'b0, r_want};

    bca_run_step u_step (
        .i_byte (r_rd_data),
        .i_len  (r_len),
        .i_want (r_want),
        .o_step (step)
    );

    // Memory port selection.
    always_comb begin
        rd_addr = (r_state == ST_SCAN) ? rd_byte_w[AW-1:0] : r_req_addr;
        wr_en   = 1'b0;
        wr_addr = r_req_addr;
        wr_data = r_rd_data;
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = 8'd0;
        end else if (r_state == ST_MOD) begin
            wr_en   = (r_mode == MODE_SET) || (r_mode == MODE_CLEAR);
            wr_data = (r_mode == MODE_SET) ? (r_rd_data | bit_mask)
                                           : (r_rd_data & ~bit_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Controller.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_init      = r_init;
        n_mode      = r_mode;
        n_req_addr  = r_req_addr;
        n_req_bit   = r_req_bit;
        n_want      = r_want;
        n_lim       = r_lim;
        n_rd_byte   = r_rd_byte;
        n_pbyte     = r_pbyte;
        n_pv        = r_pv;
        n_len       = r_len;
        n_res_found = r_res_found;
        n_res_start = r_res_start;
        n_res_bit   = r_res_bit;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_found = r_out_found;
        n_out_start = r_out_start;
        n_out_bit   = r_out_bit;

        unique case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_mode      = i_req.mode;
                    n_req_addr  = req_byte[AW-1:0];
                    n_req_bit   = i_req.bit_index[2:0];
                    n_want      = i_req.run_length;
                    n_lim       = lim_bytes;
                    n_rd_byte   = 7'd0;
                    n_pv        = 1'b0;
                    n_len       = 10'd0;
                    n_res_found = 1'b0;
                    n_res_start = 9'd0;
                    n_res_bit   = 1'b0;
                    n_state     = ST_DONE;
                    case (i_req.mode)
                        MODE_SCAN: begin
                            if ((i_req.run_length != 10'd0) &&
                                (i_req.run_length <= {lim_bytes, 3'd0})) begin
                                n_state = ST_SCAN;
                            end
                        end
                        MODE_TEST, MODE_SET, MODE_CLEAR: begin
                            // Units outside the store read as free and ignore writes.
                            if (req_byte < MAP_BYTES_W) begin
                                n_state = ST_READ;
                            end
                        end
                        MODE_CLEAR_ALL: begin
                            n_clr_addr = '0;
                            n_init     = 1'b0;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                if (r_mode == MODE_TEST) begin
                    n_res_bit = r_rd_data[r_req_bit];
                end
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // Read one byte ahead while the previous one runs through the counter.
                n_pv    = (r_rd_byte < r_lim);
                n_pbyte = r_rd_byte;
                if (r_rd_byte < r_lim) begin
                    n_rd_byte = r_rd_byte + 7'd1;
                end
                if (r_pv) begin
                    n_len = step.len;
                    if (step.hit) begin
                        n_res_found = 1'b1;
                        n_res_start = start_sum[8:0];
                        n_pv        = 1'b0;
                        n_state     = ST_DONE;
                    end else if (r_pbyte == (r_lim - 7'd1)) begin
                        n_pv    = 1'b0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_init     = 1'b0;
                    n_state    = r_init ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_start = r_res_start;
                    n_out_bit   = r_res_bit;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_init         <= 1'b1;
            r_pv           <= 1'b0;
            r_out_valid    <= 1'b0;
            r_bytes_in_use <= BYTES_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_init      <= n_init;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_bytes_in_use <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_req_addr  <= n_req_addr;
        r_req_bit   <= n_req_bit;
        r_want      <= n_want;
        r_lim       <= n_lim;
        r_rd_byte   <= n_rd_byte;
        r_pbyte     <= n_pbyte;
        r_len       <= n_len;
        r_res_found <= n_res_found;
        r_res_start <= n_res_start;
        r_res_bit   <= n_res_bit;
        r_out_found <= n_out_found;
        r_out_start <= n_out_start;
        r_out_bit   <= n_out_bit;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.start_index = r_out_start;
    assign o_rsp.bit_value   = r_out_bit;

endmodule

`default_nettype wire

>>> rtl/core/bca_checker.sv
// Port-level checks for the contiguous bitmap allocator, bound to its top level.
// Depends on bitmap_contiguous_allocator_top and its channel interfaces.
`default_nettype none

module bca_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_found,
    input wire logic [8:0] i_start_index,
    input wire logic       i_bit_value
);

    // A stalled response keeps its valid and its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_found) && $stable(i_start_index) && $stable(i_bit_value)))
        else $error("stalled response changed");

    // A run start is reported only together with found.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_start_index == 9'd0))
        else $error("start index without found");

    // Scan and test results never show up in the same response.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_found && i_bit_value))
        else $error("found and bit value both set");

    // The block works on one request at a time.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while busy");

endmodule

bind bitmap_contiguous_allocator_top bca_checker u_bca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_found       (o_rsp.found),
    .i_start_index (o_rsp.start_index),
    .i_bit_value   (o_rsp.bit_value)
);

`default_nettype wire

>>> test/bitmap_contiguous_allocator_top_test.sv
// Self-checking testbench for the contiguous first-fit bitmap allocator top level.
// Depends on bca_pkg, bca_in_if, bca_out_if and bitmap_contiguous_allocator_top.
// A scoreboard class tracks the usage map and checks every returned transfer in order.
`timescale 1ns / 100ps

module bitmap_contiguous_allocator_top_test;

    import bca_pkg::*;

    localparam int          MAP_BYTES      = 64;
    localparam logic [2:0]  MODE_LAST_CODE = 3'd7;
    localparam int unsigned STALL_LIMIT    = 3000;
    localparam int unsigned DRAIN_CYCLES   = 80;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned PHASE_ITEMS    = 50;
    localparam int unsigned MAX_REPORTS    = 40;

    // One expected response.
    typedef struct packed {
        logic       found;
        logic [8:0] start_index;
        logic       bit_value;
    } t_alloc_reply;

    // Mirrors the usage map and bytes_in_use, and holds the replies still owed.
    class allocation_tracker;
        logic [7:0]   usage_map [MAP_BYTES];
        logic [6:0]   bytes_in_use;
        t_alloc_reply awaited_replies [$];
        int unsigned  mismatches;

        function new();
            foreach (usage_map[i]) usage_map[i] = '0;
            bytes_in_use = BYTES_RESET;
            mismatches   = 0;
        endfunction

        function void set_bytes_in_use(input logic [6:0] value);
            bytes_in_use = value;
        endfunction

        function int unsigned units_in_use();
            int unsigned bytes;
            bytes = (bytes_in_use > MAP_BYTES) ? MAP_BYTES : bytes_in_use;
            return bytes * UNITS_PER_BYTE;
        endfunction

        function int unsigned pending();
            return awaited_replies.size();
        endfunction

        // Lowest run of free units of the requested length within the units in use.
        function void first_free_run(input int unsigned want, output logic hit,
                                     output logic [8:0] at);
            int unsigned units;
            int unsigned run;
            units = units_in_use();
            run   = 0;
            hit   = 1'b0;
            at    = '0;
            if (want == 0 || want > units) return;
            for (int unsigned u = 0; u < units; u++) begin
                if (usage_map[u / UNITS_PER_BYTE][u % UNITS_PER_BYTE]) run = 0;
                else run++;
                if (run == want) begin
                    hit = 1'b1;
                    at  = 9'(u + 1 - want);
                    return;
                end
            end
        endfunction

        // Apply one accepted request to the map and queue the reply it owes.
        function void note_request(input logic [2:0] mode, input logic [8:0] idx,
                                   input logic [9:0] len);
            t_alloc_reply reply;
            logic         hit;
            logic [8:0]   at;
            reply = '0;
            case (mode)
                MODE_SCAN: begin
                    first_free_run(len, hit, at);
                    reply.found       = hit;
                    reply.start_index = at;
                end
                MODE_TEST:      reply.bit_value = usage_map[idx[8:3]][idx[2:0]];
                MODE_SET:       usage_map[idx[8:3]][idx[2:0]] = 1'b1;
                MODE_CLEAR:     usage_map[idx[8:3]][idx[2:0]] = 1'b0;
                MODE_CLEAR_ALL: foreach (usage_map[i]) usage_map[i] = '0;
                default: ;
            endcase
            awaited_replies.push_back(reply);
        endfunction

        function void flag(input string field, input int unsigned expected,
                           input int unsigned actual);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", field, expected, actual);
        endfunction

        // Compare one returned transfer with the oldest owed reply.
        function void check_result(input logic found, input logic [8:0] start_index,
                                   input logic bit_value);
            t_alloc_reply owed;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("response transfer with no request outstanding");
                return;
            end
            owed = awaited_replies.pop_front();
            if (owed.found !== found) flag("found", owed.found, found);
            if (owed.start_index !== start_index)
                flag("start_index", owed.start_index, start_index);
            if (owed.bit_value !== bit_value) flag("bit_value", owed.bit_value, bit_value);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_wdata;

    bca_in_if  req_ch ();
    bca_out_if rsp_ch ();

    allocation_tracker sb = new();

    // Flags shared between the stimulus and the response side.
    bit hold_off_rsp = 1'b0;
    bit steady       = 1'b0;

    bitmap_contiguous_allocator_top #(
        .MAP_BYTES(MAP_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Observe both channels; replies are checked before the request of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.found, rsp_ch.start_index, rsp_ch.bit_value);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.mode, req_ch.bit_index, req_ch.run_length);
        end
    end

    // Response side: random stalls, one long hold-off on request, none at the end.
    initial begin
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_rsp) begin
                hold_off_rsp = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (steady) begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one request and wait for its transfer, sometimes after a random gap.
    task automatic send_req(input logic [2:0] mode, input logic [8:0] idx,
                            input logic [9:0] len);
        if (!steady && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.bit_index  <= idx;
        req_ch.run_length <= len;
        @(posedge i_clk);
        while (!(req_ch.valid && req_ch.ready)) @(posedge i_clk);
    endtask

    // Stop offering and wait until every owed reply has come back; the first
    // edge lets the observer note a request taken at the edge just passed.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write bytes_in_use while the block is idle.
    task automatic write_bytes_in_use(input logic [6:0] value);
        settle();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_bytes_in_use(value);
    endtask

    // Random request, biased toward the units in use so that scans meet real contents.
    task automatic send_random_item();
        int unsigned units;
        int unsigned pick;
        int unsigned low_units;
        logic [2:0]  mode;
        logic [8:0]  idx;
        logic [9:0]  len;
        units     = sb.units_in_use();
        low_units = (units > 64) ? 64 : units;

        pick = $urandom_range(0, 99);
        if (pick < 35) mode = MODE_SCAN;
        else if (pick < 65) mode = MODE_SET;
        else if (pick < 80) mode = MODE_CLEAR;
        else if (pick < 95) mode = MODE_TEST;
        else if (pick < 97) mode = MODE_CLEAR_ALL;
        else mode = 3'($urandom_range(MODE_CLEAR_ALL + 1, MODE_LAST_CODE));

        pick = $urandom_range(0, 99);
        if (units > 0 && pick < 40) idx = 9'($urandom_range(0, low_units - 1));
        else if (units > 0 && pick < 80) idx = 9'($urandom_range(0, units - 1));
        else idx = 9'($urandom_range(0, 511));

        pick = $urandom_range(0, 99);
        if (units > 0 && pick < 60) len = 10'($urandom_range(1, (units > 12) ? 12 : units));
        else if (pick < 75) len = 10'($urandom_range((units > 2) ? units - 2 : 0, units + 2));
        else len = 10'($urandom_range(0, 1023));

        send_req(mode, idx, len);
    endtask

    // Main sequence.
    initial begin
        logic [6:0] bytes_plan [8];
        bytes_plan = '{7'd127, 7'd2, 7'd64, 7'd0, 7'd65, 7'd1, 7'd8, 7'd64};
        bytes_plan[5] = 7'($urandom_range(1, 127));

        req_ch.valid      <= 1'b0;
        req_ch.mode       <= MODE_SCAN;
        req_ch.bit_index  <= '0;
        req_ch.run_length <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_rst_n           <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty map at the reset size: zero length, whole map, one past the map.
        send_req(MODE_SCAN, 9'd0, 10'd1);
        send_req(MODE_SCAN, 9'd0, 10'd0);
        send_req(MODE_SCAN, 9'd0, 10'd512);
        send_req(MODE_SCAN, 9'd0, 10'd513);
        send_req(MODE_SET, 9'd0, 10'd0);
        send_req(MODE_SET, 9'd511, 10'd1023);
        send_req(MODE_TEST, 9'd511, 10'd0);
        send_req(MODE_SCAN, 9'd0, 10'd511);
        send_req(MODE_SCAN, 9'd0, 10'd510);
        send_req(MODE_CLEAR, 9'd0, 10'd0);
        send_req(MODE_TEST, 9'd0, 10'd0);
        for (int m = MODE_CLEAR_ALL + 1; m <= MODE_LAST_CODE; m++)
            send_req(3'(m), 9'($urandom_range(0, 511)), 10'($urandom_range(0, 1023)));
        send_req(MODE_CLEAR_ALL, 9'd0, 10'd0);
        send_req(MODE_TEST, 9'd511, 10'd0);

        // One byte in use: fill it to get a full map, and touch a unit beyond it.
        write_bytes_in_use(7'd1);
        for (int b = 0; b < UNITS_PER_BYTE; b++) send_req(MODE_SET, 9'(b), 10'd0);
        send_req(MODE_SCAN, 9'd0, 10'd1);
        send_req(MODE_SET, 9'd300, 10'd0);
        send_req(MODE_TEST, 9'd300, 10'd0);
        send_req(MODE_CLEAR, 9'd3, 10'd0);
        send_req(MODE_SCAN, 9'd0, 10'd1);

        // No bytes in use: every scan misses.
        write_bytes_in_use(7'd0);
        send_req(MODE_SCAN, 9'd0, 10'd1);

        // Random phases over several map sizes.
        for (int p = 0; p < 8; p++) begin
            write_bytes_in_use(bytes_plan[p]);
            if (p == 1) hold_off_rsp = 1'b1;
            if (p == 7) steady = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
        end

        // Drain, then give the block time to show any stray response.
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bca_pkg.sv
rtl/core/bca_in_if.sv
rtl/core/bca_out_if.sv
rtl/core/bca_run_step.sv
rtl/core/bitmap_contiguous_allocator_top.sv
rtl/core/bca_checker.sv
test/bitmap_contiguous_allocator_top_test.sv
